// ===== hw/rtl/rotating_dot_display_engine_defines.svh =====
// Assertion macros for the rotating dot display engine.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef ROTATING_DOT_DISPLAY_ENGINE_DEFINES_SVH
`define ROTATING_DOT_DISPLAY_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RDDE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RDDE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rdde_pkg.sv =====
// Shared types, codes and tables of the rotating dot display engine.
// No dependencies; used by the controller, the datapath and the top level.
package rdde_pkg;

  localparam int BitmapBytesDef = 128;
  localparam int CfgIdxW        = 2;
  localparam int CfgDataW       = 32;
  localparam int DigitCount     = 12;
  localparam int SegSkew        = 11;

  typedef enum logic [2:0] {
    CmdTick  = 3'd0,
    CmdEdge  = 3'd1,
    CmdSet   = 3'd2,
    CmdMask  = 3'd3,
    CmdDigit = 3'd4,
    CmdClear = 3'd5
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRampInterval = 2'd0,
    CfgTargetSpeed  = 2'd1,
    CfgDriveLevel   = 2'd2,
    CfgLightOffset  = 2'd3
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // request accepted: latch operands, update motor state
    logic clr_step;  // write one zero byte of the clearing sweep
    logic adr;       // first half of the byte address reduction
    logic led_sel;   // address the LED dot instead of a segment dot
    logic rd;        // read the bitmap byte
    logic wr;        // write back the modified byte
    logic seg_inc;   // move to the next segment
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic seg_last;
  } dp_stat_t;

  localparam logic [15:0] SegOffset [8] = '{
    16'd512, 16'(853 + SegSkew), 16'(683 + SegSkew), 16'd171,
    16'(683 - SegSkew), 16'(853 - SegSkew), 16'd341, 16'd0
  };

  function automatic logic [7:0] digit_mask(logic [3:0] code);
    logic [7:0] m;
    case (code)
      4'd0:    m = 8'h3F;
      4'd1:    m = 8'h06;
      4'd2:    m = 8'h5B;
      4'd3:    m = 8'h4F;
      4'd4:    m = 8'h66;
      4'd5:    m = 8'h6D;
      4'd6:    m = 8'h7D;
      4'd7:    m = 8'h07;
      4'd8:    m = 8'h7F;
      4'd9:    m = 8'h6F;
      4'd10:   m = 8'h80;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/rotating_dot_display_engine.sv =====
// Top level of the rotating dot display engine.
// Depends on rdde_pkg, rdde_ctrl, rdde_dpath and the assertion macro header.
//
// A request is taken when start_i is high and busy_o is low; one result follows,
// shown for the single cycle in which done_o is high, and the receiver cannot
// stall it. A bitmap write takes an address reduction, a memory read and a write
// back, and every request ends with a read of the LED dot. A set-bit writes one
// dot, a mask or digit draw eight (a digit code above 11 writes none), a tick,
// detector edge or unused command none, and a clear first zeroes all BitmapBytes
// bytes. After reset the bitmap is swept to zero, one byte per cycle, with busy_o
// high; configuration writes are taken at any time, cfg_ready_o is always high.
`include "rotating_dot_display_engine_defines.svh"

module rotating_dot_display_engine #(
  parameter int BitmapBytes = rdde_pkg::BitmapBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  output logic                          done_o,
  input  logic [2:0]                    cmd_i,
  input  logic [15:0]                   draw_angle_i,
  input  logic                          bit_value_i,
  input  logic [7:0]                    mask_bits_i,
  input  logic [3:0]                    digit_code_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rdde_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rdde_pkg::CfgDataW-1:0] cfg_data_i,
  output logic [15:0]                   motor_angle_o,
  output logic [7:0]                    drive_out_o,
  output logic                          led_on_o,
  output logic [9:0]                    latched_angle_o,
  output logic                          spinning_o,
  output logic [63:0]                   tick_total_o
);
  import rdde_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;
  logic     accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = start_i & ~busy_o;

  rdde_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .op_i         (cmd_i),
    .digit_code_i (digit_code_i),
    .stat_i       (stat),
    .ctl_o        (ctl),
    .busy_o       (busy_o),
    .done_o       (done_o)
  );

  rdde_dpath #(
    .BitmapBytes (BitmapBytes)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .stat_o          (stat),
    .op_i            (cmd_i),
    .draw_angle_i    (draw_angle_i),
    .bit_value_i     (bit_value_i),
    .mask_bits_i     (mask_bits_i),
    .digit_code_i    (digit_code_i),
    .cfg_valid_i     (cfg_valid_i & cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .motor_angle_o   (motor_angle_o),
    .drive_out_o     (drive_out_o),
    .led_on_o        (led_on_o),
    .latched_angle_o (latched_angle_o),
    .spinning_o      (spinning_o),
    .tick_total_o    (tick_total_o)
  );

  `RDDE_ASSERT_NXT(a_done_single, done_o, !done_o, "result strobe held for two cycles")
  `RDDE_ASSERT_NXT(a_accept_busy, accept, busy_o, "block not busy after accepting a request")
  `RDDE_ASSERT_IMP(a_done_busy, done_o, busy_o, "result given while idle")
  `RDDE_ASSERT_NXT(a_tick_count, accept && (cmd_i == 3'(CmdTick)), tick_total_o == $past(tick_total_o) + 64'd1, "tick counter did not advance on a tick")

endmodule

// ===== hw/rtl/rdde_ctrl.sv =====
// Sequencer of the rotating dot display engine.
// Depends on rdde_pkg; drives the datapath through dp_cmd_t.
module rdde_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [2:0]         op_i,
  input  logic [3:0]         digit_code_i,
  input  rdde_pkg::dp_stat_t stat_i,
  output rdde_pkg::dp_cmd_t  ctl_o,
  output logic               busy_o,
  output logic               done_o
);
  import rdde_pkg::*;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StClear = 6'b000010,
    StAdr   = 6'b000100,
    StRd    = 6'b001000,
    StWr    = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   led_q, led_d;
  logic   clr_cmd_q, clr_cmd_d;

  always_comb begin
    state_d   = state_q;
    led_d     = led_q;
    clr_cmd_d = clr_cmd_q;
    ctl_o     = '0;
    ctl_o.led_sel = led_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          state_d    = StAdr;
          case (cmd_e'(op_i))
            CmdClear: begin
              clr_cmd_d = 1'b1;
              state_d   = StClear;
            end
            CmdSet, CmdMask: led_d = 1'b0;
            CmdDigit: led_d = (digit_code_i >= 4'(DigitCount));
            default:  led_d = 1'b1;
          endcase
        end
      end
      StClear: begin
        ctl_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          clr_cmd_d = 1'b0;
          led_d     = 1'b1;
          state_d   = clr_cmd_q ? StAdr : StIdle;
        end
      end
      StAdr: begin
        ctl_o.adr = 1'b1;
        state_d   = StRd;
      end
      StRd: begin
        ctl_o.rd = 1'b1;
        state_d  = led_q ? StOut : StWr;
      end
      StWr: begin
        ctl_o.wr = 1'b1;
        state_d  = StAdr;
        if (stat_i.seg_last) begin
          led_d = 1'b1;
        end else begin
          ctl_o.seg_inc = 1'b1;
        end
      end
      StOut: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Reset starts the clearing sweep of the bitmap.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      led_q     <= 1'b0;
      clr_cmd_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      led_q     <= led_d;
      clr_cmd_q <= clr_cmd_d;
    end
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = (state_q == StOut);

endmodule

// ===== hw/rtl/rdde_dpath.sv =====
// Datapath of the rotating dot display engine: motor state, configuration,
// bitmap memory and byte address reduction. Depends on rdde_pkg.
module rdde_dpath #(
  parameter int BitmapBytes = rdde_pkg::BitmapBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rdde_pkg::dp_cmd_t             ctl_i,
  output rdde_pkg::dp_stat_t            stat_o,
  input  logic [2:0]                    op_i,
  input  logic [15:0]                   draw_angle_i,
  input  logic                          bit_value_i,
  input  logic [7:0]                    mask_bits_i,
  input  logic [3:0]                    digit_code_i,
  input  logic                          cfg_valid_i,
  input  logic [rdde_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rdde_pkg::CfgDataW-1:0] cfg_data_i,
  output logic [15:0]                   motor_angle_o,
  output logic [7:0]                    drive_out_o,
  output logic                          led_on_o,
  output logic [9:0]                    latched_angle_o,
  output logic                          spinning_o,
  output logic [63:0]                   tick_total_o
);
  import rdde_pkg::*;

  localparam int AW   = $clog2(BitmapBytes);
  localparam int DotW = 13;                       // angle bits above the dot index
  localparam int QW   = $clog2((1 << DotW) / BitmapBytes + 1);
  localparam int QH   = QW / 2;
  localparam int XW   = DotW + 2;
  localparam logic [XW-1:0] NX = XW'(BitmapBytes);

  // Motor and configuration state.
  logic [31:0] phase_q, speed_q, target_q;
  logic [7:0]  ramp_q, drive_q;
  logic [6:0]  ramp_int_q;
  logic [63:0] ticks_q;
  logic [15:0] angle_q, offset_q;
  logic [9:0]  edge_q;
  logic        seen_q;

  // Draw operands and sequencing.
  logic [15:0]   base_q;
  logic [7:0]    mask_q;
  logic [2:0]    seg_q;
  logic [AW-1:0] clr_q;

  // Address reduction and memory.
  logic [15:0]    probe_angle;
  logic [XW-1:0]  rem1, rem2;
  logic [DotW-1:0] rem_q;
  logic [2:0]     bsel_q;
  logic [AW-1:0]  rd_addr, addr_q, wr_addr;
  logic [7:0]     rd_data_q, wr_data, bit_sel;
  logic           wr_en;
  logic [7:0]     bitmap_q [BitmapBytes];

  logic [7:0] ramp_next;

  assign ramp_next = ramp_q + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      speed_q    <= '0;
      ramp_q     <= '0;
      ticks_q    <= '0;
      angle_q    <= '0;
      edge_q     <= '0;
      seen_q     <= 1'b0;
      ramp_int_q <= '0;
      target_q   <= '0;
      drive_q    <= '0;
      offset_q   <= '0;
      seg_q      <= '0;
      clr_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgRampInterval: ramp_int_q <= cfg_data_i[6:0];
          CfgTargetSpeed:  target_q   <= cfg_data_i;
          CfgDriveLevel:   drive_q    <= cfg_data_i[7:0];
          CfgLightOffset:  offset_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (ctl_i.load) begin
        seg_q <= (cmd_e'(op_i) == CmdSet) ? 3'd7 : 3'd0;
        case (cmd_e'(op_i))
          CmdTick: begin
            angle_q <= phase_q[31:16];
            phase_q <= phase_q + speed_q;
            ticks_q <= ticks_q + 64'd1;
            if (ramp_next == {1'b0, ramp_int_q}) begin
              ramp_q <= '0;
              if (speed_q < target_q) begin
                speed_q <= speed_q + 32'd1;
              end
            end else begin
              ramp_q <= ramp_next;
            end
          end
          CmdEdge: begin
            edge_q <= angle_q[9:0];
            seen_q <= 1'b1;
          end
          default: ;
        endcase
      end else if (ctl_i.seg_inc) begin
        seg_q <= seg_q + 3'd1;
      end
      if (ctl_i.clr_step) begin
        clr_q <= stat_o.clr_last ? '0 : clr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      base_q <= draw_angle_i;
      case (cmd_e'(op_i))
        CmdSet:   mask_q <= {bit_value_i, 7'd0};
        CmdMask:  mask_q <= mask_bits_i;
        CmdDigit: mask_q <= digit_mask(digit_code_i);
        default:  mask_q <= mask_q;
      endcase
    end
  end

  assign stat_o.clr_last = (clr_q == AW'(BitmapBytes - 1));
  assign stat_o.seg_last = (seg_q == 3'd7);

  // Byte index is (angle / 8) mod BitmapBytes, reduced by conditional
  // subtraction of shifted multiples, in two halves with rem_q registered between.
  assign probe_angle = ctl_i.led_sel ? angle_q + offset_q : base_q + SegOffset[seg_q];

  always_comb begin
    rem1 = XW'(probe_angle[15:3]);
    for (int j = QW - 1; j >= QH; j--) begin
      if (rem1 >= (NX << j)) rem1 = rem1 - (NX << j);
    end
  end

  always_comb begin
    rem2 = XW'(rem_q);
    for (int j = QH - 1; j >= 0; j--) begin
      if (rem2 >= (NX << j)) rem2 = rem2 - (NX << j);
    end
  end

  assign rd_addr = rem2[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.adr) begin
      rem_q  <= rem1[DotW-1:0];
      bsel_q <= probe_angle[2:0];
    end
    if (ctl_i.rd) begin
      addr_q    <= rd_addr;
      rd_data_q <= bitmap_q[rd_addr];
    end
  end

  assign bit_sel = 8'd1 << bsel_q;
  assign wr_data = ctl_i.clr_step ? 8'd0 :
                   (mask_q[seg_q] ? (rd_data_q | bit_sel) : (rd_data_q & ~bit_sel));
  assign wr_addr = ctl_i.clr_step ? clr_q : addr_q;
  assign wr_en   = ctl_i.clr_step | ctl_i.wr;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bitmap_q[wr_addr] <= wr_data;
    end
  end

  assign motor_angle_o   = angle_q;
  assign drive_out_o     = drive_q;
  assign led_on_o        = rd_data_q[bsel_q];
  assign latched_angle_o = edge_q;
  assign spinning_o      = seen_q;
  assign tick_total_o    = ticks_q;

endmodule
